/* design/kst_pkg.sv */
// package for the key slot table: sizes, codes and transaction types
`timescale 1ns / 1ps

package kst_pkg;

	// table size and derived widths
	localparam int SLOT_COUNT = 1024;
	localparam int IDX_W      = $clog2(SLOT_COUNT);
	localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

	// fixed field widths of the transactions
	localparam int ACTION_W   = 2;
	localparam int IDENT_W    = 32;
	localparam int PERM_W     = 32;
	localparam int STATUS_W   = 2;
	localparam int SLOT_IDX_W = 10;
	localparam int LIVE_W     = 11;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd3;

	// command transaction
	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [IDENT_W-1:0]  key_ident;
		logic [PERM_W-1:0]   perm_word;
	} cmd_t;

	// result transaction
	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [SLOT_IDX_W-1:0] slot_index;
		logic [PERM_W-1:0]     found_perms;
		logic [LIVE_W-1:0]     live_count;
	} rsp_t;

	// contents of one slot
	typedef struct packed {
		logic               valid;
		logic [IDENT_W-1:0] ident;
		logic [PERM_W-1:0]  perms;
	} slot_t;

	// controls from the sequencer to the ring of cells
	typedef struct packed {
		logic             shift;
		logic             clear;
		logic             wr_en;
		logic [IDX_W-1:0] wr_idx;
		slot_t            wr_data;
	} ring_ctrl_t;

endpackage

/* design/kst_cell.sv */
// one slot cell: holds an entry, takes its neighbor's entry on a shift
`timescale 1ns / 1ps

module kst_cell
	import kst_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  shift,
	input  logic  clear,
	input  logic  wr_sel,
	input  slot_t shift_in,
	input  slot_t wr_data,
	output slot_t slot
);

	logic               valid_q;
	logic [IDENT_W-1:0] ident_q;
	logic [PERM_W-1:0]  perms_q;

	// valid mark: clear wins, then write, then shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else if (wr_sel) begin
			valid_q <= wr_data.valid;
		end else if (shift) begin
			valid_q <= shift_in.valid;
		end
	end

	// identifier and permissions
	always_ff @(posedge clk) begin
		if (wr_sel) begin
			ident_q <= wr_data.ident;
			perms_q <= wr_data.perms;
		end else if (shift) begin
			ident_q <= shift_in.ident;
			perms_q <= shift_in.perms;
		end
	end

	assign slot.valid = valid_q;
	assign slot.ident = ident_q;
	assign slot.perms = perms_q;

endmodule

/* design/kst_ring.sv */
// circular chain of slot cells; cell 0 is the head seen by the sequencer
`timescale 1ns / 1ps

module kst_ring
	import kst_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  ring_ctrl_t ctrl,
	output slot_t      head
);

	slot_t cell_out [SLOT_COUNT];

	// each cell takes the entry of the next one, the last wraps to the head
	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		logic wr_sel;

		assign wr_sel = ctrl.wr_en && (ctrl.wr_idx == IDX_W'(i));

		kst_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (ctrl.shift),
			.clear    (ctrl.clear),
			.wr_sel   (wr_sel),
			.shift_in (cell_out[(i + 1) % SLOT_COUNT]),
			.wr_data  (ctrl.wr_data),
			.slot     (cell_out[i])
		);
	end

	assign head = cell_out[0];

endmodule

/* design/key_slot_table.sv */
// key slot table top level: command sequencer over a rotating ring of slot cells
`timescale 1ns / 1ps

// Insert and lookup commands rotate the whole ring of SLOT_COUNT cells once past the
// head cell, one slot per clock, and then pass through the finish state, which writes the
// claimed slot and forms the result. Clear and unused action codes skip the rotation and
// go straight to the finish state. A new command is accepted only while busy is low.
// The result appears on rsp with done high for exactly one cycle, the cycle right after
// busy falls; it is not held, so the receiver must take it then. A start may be issued
// in that same cycle.

module key_slot_table
	import kst_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output rsp_t rsp
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;

	logic [1:0]       state_q;
	cmd_t             cmd_q;
	logic [IDX_W-1:0] step_q;
	logic [CNT_W-1:0] count_q;
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [PERM_W-1:0] hit_perms_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             done_q;
	rsp_t             rsp_q;

	ring_ctrl_t       ctrl;
	slot_t            head;
	logic             accept;
	logic             head_match;
	logic             last_step;
	logic             table_full;
	logic             do_insert;

	assign accept     = start && (state_q == S_IDLE);
	assign head_match = head.valid && (head.ident == cmd_q.key_ident);
	assign last_step  = (step_q == IDX_W'(SLOT_COUNT - 1));
	assign table_full = (count_q == CNT_W'(SLOT_COUNT));
	assign do_insert  = (state_q == S_FINISH) && (cmd_q.action == ACT_INSERT) &&
	                    !hit_q && !table_full && free_q;

	// ring controls
	always_comb begin
		ctrl               = '0;
		ctrl.shift         = (state_q == S_SCAN);
		ctrl.clear         = (state_q == S_FINISH) && (cmd_q.action == ACT_CLEAR);
		ctrl.wr_en         = do_insert;
		ctrl.wr_idx        = free_idx_q;
		ctrl.wr_data.valid = 1'b1;
		ctrl.wr_data.ident = cmd_q.key_ident;
		ctrl.wr_data.perms = cmd_q.perm_word;
	end

	kst_ring u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.head   (head)
	);

	// command latch
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
	end

	// sequencer, scan trackers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			count_q <= '0;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						step_q <= '0;
						hit_q  <= 1'b0;
						free_q <= 1'b0;
						if (cmd.action == ACT_INSERT || cmd.action == ACT_LOOKUP) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_SCAN: begin
					if (head_match && !hit_q) begin
						hit_q <= 1'b1;
					end
					if (!head.valid && !free_q) begin
						free_q <= 1'b1;
					end
					step_q <= step_q + 1'b1;
					if (last_step) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (ctrl.clear) begin
						count_q <= '0;
					end else if (do_insert) begin
						count_q <= count_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// first match and first free slot seen at the head
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN) begin
			if (head_match && !hit_q) begin
				hit_idx_q   <= step_q;
				hit_perms_q <= head.perms;
			end
			if (!head.valid && !free_q) begin
				free_idx_q <= step_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == S_FINISH) begin
			rsp_q.status      <= ST_MISS;
			rsp_q.slot_index  <= '0;
			rsp_q.found_perms <= '0;
			rsp_q.live_count  <= LIVE_W'(count_q);
			case (cmd_q.action)
				ACT_INSERT: begin
					if (hit_q) begin
						rsp_q.status <= ST_DUP;
					end else if (do_insert) begin
						rsp_q.status      <= ST_OK;
						rsp_q.slot_index  <= SLOT_IDX_W'(free_idx_q);
						rsp_q.found_perms <= cmd_q.perm_word;
						rsp_q.live_count  <= LIVE_W'(count_q + 1'b1);
					end else begin
						rsp_q.status <= ST_FULL;
					end
				end
				ACT_LOOKUP: begin
					if (hit_q) begin
						rsp_q.status      <= ST_OK;
						rsp_q.slot_index  <= SLOT_IDX_W'(hit_idx_q);
						rsp_q.found_perms <= hit_perms_q;
					end
				end
				ACT_CLEAR: begin
					rsp_q.status     <= ST_OK;
					rsp_q.live_count <= '0;
				end
				default: begin
					rsp_q.status <= ST_MISS;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef SYNTHESIS
	// an accepted command makes the block busy in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	// a result strobe always follows a busy cycle
	assert property (@(posedge clk) disable iff (!arst_n) done |-> $past(busy))
		else $error("result strobe without a command in progress");

	// the live count never exceeds the table size
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(SLOT_COUNT))
		else $error("live count above table size");

	// a duplicate report carries no slot and no permissions
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_DUP) |-> (rsp.slot_index == '0 && rsp.found_perms == '0))
		else $error("duplicate result with slot data");
`endif

endmodule
